### rtl/core/button_debounce_long_press_unit_defines.svh
// ---------------------------------------------------------------------------
// Button debounce and long-press unit: assertion macros
// Assertion helpers clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define BDLP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define BDLP_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BDLP_ASSERT(label, prop, msg)
`define BDLP_ASSERT_NEVER(label, cond, msg)
`endif

`endif

### rtl/core/bdlp_pkg.sv
// ---------------------------------------------------------------------------
// Button debounce and long-press unit: package
// Payload structs, phase and event codes, register indexes.
// ---------------------------------------------------------------------------
package bdlp_pkg;

	localparam int TIME_WIDTH_DEF = 16;
	localparam int CFG_TIME_W     = 16;
	localparam int BUTTON_ID_W    = 8;
	localparam int CFG_INDEX_W    = 2;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_DEBOUNCE  = 2'd1,
		PH_WAIT_LONG = 2'd2
	} bdlp_phase_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_UPDATED = 2'd1,
		EV_SHORT   = 2'd2,
		EV_LONG    = 2'd3
	} bdlp_event_t;

	typedef enum logic {
		REQ_TICK = 1'b0,
		REQ_POLL = 1'b1
	} bdlp_req_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEBOUNCE_TIME   = 2'd0,
		REG_LONG_PRESS_TIME = 2'd1,
		REG_BUTTON_ID       = 2'd2
	} bdlp_reg_t;

	localparam logic [CFG_TIME_W-1:0]  DEBOUNCE_RST   = 16'd20;
	localparam logic [CFG_TIME_W-1:0]  LONG_PRESS_RST = 16'd1000;
	localparam logic [BUTTON_ID_W-1:0] BUTTON_ID_RST  = 8'd0;

	typedef struct packed {
		logic                  req_type;
		logic [CFG_TIME_W-1:0] tick_period;
		logic                  pin_level;
	} bdlp_in_t;

	typedef struct packed {
		logic [1:0]             event_code;
		logic                   pressed_now;
		logic [BUTTON_ID_W-1:0] event_button;
	} bdlp_out_t;

endpackage

### rtl/core/button_debounce_long_press_unit.sv
// Datapath: an accepted transaction is captured in the input stage, then
// evaluated and stored in the result register once that register is free or draining; out_valid is high after it.
// Throughput: one transaction per cycle unless out_ready stalls the result register;
// the phase/countdown update is one subtract and compare between the input stage and the result register.
// Reset: phase idle, countdown zero, level released, registers at their defaults.
// ---------------------------------------------------------------------------
// Button debounce and long-press unit
// Qualifies sampled button levels against a tick-driven countdown and reports
// state updates, short presses and long presses.
// ---------------------------------------------------------------------------
`include "button_debounce_long_press_unit_defines.svh"

module button_debounce_long_press_unit #(
	parameter int TIME_WIDTH = bdlp_pkg::TIME_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  bdlp_pkg::bdlp_in_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output bdlp_pkg::bdlp_out_t                   out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bdlp_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [bdlp_pkg::CFG_TIME_W-1:0]       cfg_data
);
	import bdlp_pkg::*;

	// compare width covers both the countdown and the 16-bit register values
	localparam int CW = (TIME_WIDTH > CFG_TIME_W) ? TIME_WIDTH : CFG_TIME_W;
	localparam logic [CW-1:0] TIME_MAX = CW'({TIME_WIDTH{1'b1}});

	// -----------------------------------------------------------------------
	// Configuration registers: always ready, and it is up to the user to write them only while idle
	// -----------------------------------------------------------------------
	logic [CFG_TIME_W-1:0]  debounce_time_q;
	logic [CFG_TIME_W-1:0]  long_press_time_q;
	logic [BUTTON_ID_W-1:0] button_id_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_time_q   <= DEBOUNCE_RST;
			long_press_time_q <= LONG_PRESS_RST;
			button_id_q       <= BUTTON_ID_RST;
		end else if (cfg_valid) begin
			case (bdlp_reg_t'(cfg_index))
				REG_DEBOUNCE_TIME:   debounce_time_q   <= cfg_data;
				REG_LONG_PRESS_TIME: long_press_time_q <= cfg_data;
				REG_BUTTON_ID:       button_id_q       <= cfg_data[BUTTON_ID_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp a 16-bit time register to the countdown width
	function automatic logic [TIME_WIDTH-1:0] clamp_time(input logic [CFG_TIME_W-1:0] v);
		logic [CW-1:0] ext;
		ext = CW'(v);
		if (ext > TIME_MAX)
			clamp_time = {TIME_WIDTH{1'b1}};
		else
			clamp_time = ext[TIME_WIDTH-1:0];
	endfunction

	// -----------------------------------------------------------------------
	// Handshake: input stage advances whenever the result register is free
	// or being drained, so the output register decouples the two sides.
	// -----------------------------------------------------------------------
	logic     valid_s1;
	bdlp_in_t data_s1;
	logic     advance;

	assign advance  = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	// -----------------------------------------------------------------------
	// Qualifier state
	// -----------------------------------------------------------------------
	bdlp_phase_t           phase_q, phase_d;
	logic [TIME_WIDTH-1:0] countdown_q, countdown_d;
	logic                  level_q, level_d;
	bdlp_event_t           ev_d;

	logic                  commit;
	logic                  cd_zero;
	logic                  level_diff;
	logic [CW-1:0]         cd_ext;
	logic [CW-1:0]         period_ext;

	assign commit     = valid_s1 && advance;
	assign cd_zero    = (countdown_q == '0);
	assign level_diff = (data_s1.pin_level != level_q);
	assign cd_ext     = CW'(countdown_q);
	assign period_ext = CW'(data_s1.tick_period);

	// next state: tick saturates the countdown; poll steps the phase machine
	always_comb begin
		phase_d     = phase_q;
		countdown_d = countdown_q;
		level_d     = level_q;
		if (data_s1.req_type == REQ_TICK) begin
			if (cd_ext > period_ext)
				countdown_d = TIME_WIDTH'(cd_ext - period_ext);
			else
				countdown_d = '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (cd_zero && level_diff) begin
						phase_d     = PH_DEBOUNCE;
						countdown_d = clamp_time(debounce_time_q);
					end
				end
				PH_DEBOUNCE: begin
					if (cd_zero) begin
						if (level_diff) begin
							level_d = data_s1.pin_level;
							if (data_s1.pin_level) begin
								phase_d     = PH_WAIT_LONG;
								countdown_d = clamp_time(long_press_time_q);
							end else begin
								phase_d     = PH_IDLE;
								countdown_d = clamp_time(debounce_time_q);
							end
						end else begin
							// level bounced back: restart from idle
							phase_d     = PH_IDLE;
							countdown_d = clamp_time(debounce_time_q);
						end
					end
				end
				PH_WAIT_LONG: begin
					if (level_diff) begin
						phase_d     = PH_DEBOUNCE;
						countdown_d = clamp_time(debounce_time_q);
					end else if (cd_zero && (long_press_time_q != '0)) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// event output for the item in the input stage
	always_comb begin
		ev_d = EV_NONE;
		if (data_s1.req_type == REQ_POLL) begin
			case (phase_q)
				PH_DEBOUNCE: begin
					if (cd_zero && level_diff)
						ev_d = EV_UPDATED;
				end
				PH_WAIT_LONG: begin
					if (level_diff)
						ev_d = EV_SHORT;
					else if (cd_zero && (long_press_time_q != '0))
						ev_d = EV_LONG;
				end
				default: ev_d = EV_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			countdown_q <= '0;
			level_q     <= 1'b0;
		end else if (commit) begin
			phase_q     <= phase_d;
			countdown_q <= countdown_d;
			level_q     <= level_d;
		end
	end

	// -----------------------------------------------------------------------
	// Result register: holds while the consumer stalls
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data.event_code   <= ev_d;
			out_data.pressed_now  <= level_d;
			out_data.event_button <= button_id_q;
		end
	end

	// -----------------------------------------------------------------------
	// Checks
	// -----------------------------------------------------------------------
	// accepted level moves only with a state-updated event
	`BDLP_ASSERT(a_level_change_has_update, (level_q != $past(level_q)) |-> ($past(commit) && ($past(ev_d) == EV_UPDATED)), "level changed without update event")
	// short and long presses are only reported while the button is held
	`BDLP_ASSERT_NEVER(a_press_while_released, out_valid && !out_data.pressed_now && (out_data.event_code == EV_SHORT || out_data.event_code == EV_LONG), "press event with released level")
	// an empty result register never blocks the input
	`BDLP_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty result register")
	// a long press is only seen in the wait-long phase
	`BDLP_ASSERT_NEVER(a_long_outside_wait, commit && (ev_d == EV_LONG) && (phase_q != PH_WAIT_LONG), "long press outside wait phase")

endmodule

### tb/button_debounce_long_press_unit_tb.sv
// ---------------------------------------------------------------------------
// Button debounce and long-press unit: self-checking testbench
// Drives tick and poll transactions into the unit, predicts every event with
// an independent model of the debounce machine and compares each result
// field by field. Random gaps and output stalls, one long hold-off.
// ---------------------------------------------------------------------------
module button_debounce_long_press_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bdlp_pkg::*;

	localparam int TB_TIME_W = TIME_WIDTH_DEF;
	localparam logic [TB_TIME_W-1:0] TIME_MAX = '1;
	// index past the last register: the unit must ignore writes to it
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_PAUSE = 4;

	// DUT connections
	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	bdlp_in_t               in_data;
	logic                   out_valid;
	logic                   out_ready;
	bdlp_out_t              out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_TIME_W-1:0]  cfg_data;

	// predictor state and register copies
	bdlp_phase_t            pred_phase;
	logic [TB_TIME_W-1:0]   pred_count;
	logic                   pred_level;
	logic [CFG_TIME_W-1:0]  set_db;
	logic [CFG_TIME_W-1:0]  set_lp;
	logic [BUTTON_ID_W-1:0] set_id;

	bdlp_out_t predicted_events[$];

	// traffic shaping, percent chance of a gap
	int tx_gap_pct;
	int rx_stall_pct;
	int hold_off_cycles;
	// physical button level behind the random polls
	logic held_level;

	int cycle_count;
	int mismatch_count;
	int items_sent;
	int results_checked;
	int settings_used;
	int event_seen[4];

	button_debounce_long_press_unit #(
		.TIME_WIDTH(TB_TIME_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("button_debounce_long_press_unit_tb: done, errors");
			$finish;
		end
	end

	// -----------------------------------------------------------------------
	// Predictor
	// -----------------------------------------------------------------------

	// loaded times saturate at the countdown width
	function automatic logic [TB_TIME_W-1:0] load_time(input logic [CFG_TIME_W-1:0] t);
		return (32'(t) > 32'(TIME_MAX)) ? TIME_MAX : TB_TIME_W'(t);
	endfunction

	function automatic bdlp_out_t debounce_step(input bdlp_in_t item);
		bdlp_event_t ev;
		bdlp_out_t   res;
		ev = EV_NONE;
		if (item.req_type == REQ_TICK) begin
			// ticks only run the countdown down, stopping at zero
			pred_count = (pred_count > item.tick_period) ?
				pred_count - item.tick_period : '0;
		end else begin
			case (pred_phase)
				PH_IDLE: begin
					if (pred_count == 0 && item.pin_level != pred_level) begin
						pred_phase = PH_DEBOUNCE;
						pred_count = load_time(set_db);
					end
				end
				PH_DEBOUNCE: begin
					// nothing happens until the debounce window has run out
					if (pred_count == 0) begin
						if (item.pin_level != pred_level) begin
							pred_level = item.pin_level;
							ev = EV_UPDATED;
							if (item.pin_level) begin
								pred_phase = PH_WAIT_LONG;
								pred_count = load_time(set_lp);
							end else begin
								pred_phase = PH_IDLE;
								pred_count = load_time(set_db);
							end
						end else begin
							// level bounced back: restart from idle
							pred_phase = PH_IDLE;
							pred_count = load_time(set_db);
						end
					end
				end
				PH_WAIT_LONG: begin
					if (item.pin_level != pred_level) begin
						pred_phase = PH_DEBOUNCE;
						pred_count = load_time(set_db);
						ev = EV_SHORT;
					end else if (pred_count == 0 && set_lp != 0) begin
						// zero hold time keeps us here until release
						pred_phase = PH_IDLE;
						ev = EV_LONG;
					end
				end
				default: begin
					// unused phase code falls back to idle
					pred_phase = PH_IDLE;
				end
			endcase
		end
		res.event_code   = ev;
		res.pressed_now  = pred_level;
		res.event_button = set_id;
		return res;
	endfunction

	// -----------------------------------------------------------------------
	// Output side: stall generator and result checker
	// -----------------------------------------------------------------------

	// each pass: an optional stall with out_ready low, then out_ready high again,
	// so out_ready never gets two assignments in one time step
	initial begin : receiver
		int n;
		forever begin
			if (hold_off_cycles > 0) begin
				n = hold_off_cycles;
				hold_off_cycles = 0;
			end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
				n = $urandom_range(1, 5);
			end else begin
				n = 0;
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// values read here are the ones present just before the edge
	always @(posedge clk) begin
		bdlp_out_t want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			event_seen[out_data.event_code]++;
			if (predicted_events.size() == 0) begin
				$error("unexpected result: event_code %0d pressed_now %0b event_button %0d",
					out_data.event_code, out_data.pressed_now, out_data.event_button);
				mismatch_count++;
			end else begin
				want = predicted_events.pop_front();
				if (out_data.event_code !== want.event_code) begin
					$error("event_code: expected %0d, got %0d",
						want.event_code, out_data.event_code);
					mismatch_count++;
				end
				if (out_data.pressed_now !== want.pressed_now) begin
					$error("pressed_now: expected %0b, got %0b",
						want.pressed_now, out_data.pressed_now);
					mismatch_count++;
				end
				if (out_data.event_button !== want.event_button) begin
					$error("event_button: expected %0d, got %0d",
						want.event_button, out_data.event_button);
					mismatch_count++;
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Input side
	// -----------------------------------------------------------------------

	// one transaction; valid stays high afterwards unless the next call
	// opens a gap or drain_unit lowers it
	task automatic send_item(input bdlp_req_t req, input logic [CFG_TIME_W-1:0] period,
			input logic level);
		bdlp_in_t item;
		item.req_type    = req;
		item.tick_period = period;
		item.pin_level   = level;
		if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted_events.push_back(debounce_step(item));
		items_sent++;
	endtask

	// stop offering, wait for every predicted event, then let the pipe settle
	task automatic drain_unit();
		in_valid <= 1'b0;
		@(posedge clk);
		while (predicted_events.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	// cfg_valid stays high across back-to-back writes
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_TIME_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_DEBOUNCE_TIME:   set_db = value;
			REG_LONG_PRESS_TIME: set_lp = value;
			REG_BUTTON_ID:       set_id = value[BUTTON_ID_W-1:0];
			default:             ;
		endcase
	endtask

	// only while idle; the spare index gets junk that must change nothing
	task automatic program_regs(input logic [CFG_TIME_W-1:0] db,
			input logic [CFG_TIME_W-1:0] lp, input logic [BUTTON_ID_W-1:0] id);
		drain_unit();
		write_reg(REG_DEBOUNCE_TIME, db);
		write_reg(REG_LONG_PRESS_TIME, lp);
		// upper bits of the id write are junk and must be dropped
		write_reg(REG_BUTTON_ID, {8'($urandom), id});
		write_reg(REG_SPARE, 16'($urandom));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [CFG_TIME_W-1:0] pick_period(input int unsigned span);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 16'($urandom);
			default: return 16'($urandom_range(0, span));
		endcase
	endfunction

	// press/release episodes: the held level flips now and then, polls
	// see it with occasional contact bounce, ticks are scaled to the
	// programmed times so both long and short presses come up
	task automatic send_random(input int n);
		int unsigned span;
		logic        level;
		repeat (n) begin
			span = ((set_db > set_lp) ? set_db : set_lp) / 3 + 1;
			if ($urandom_range(0, 7) == 0)
				held_level = ~held_level;
			if ($urandom_range(0, 1)) begin
				send_item(REQ_TICK, pick_period(span), 1'($urandom));
			end else begin
				level = ($urandom_range(0, 9) == 0) ? ~held_level : held_level;
				send_item(REQ_POLL, 16'($urandom), level);
			end
		end
	endtask

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	// reset values: 20 debounce, 1000 hold, id 0; walk through a full
	// press that ends in a long press, then a bounce back to the old level
	task automatic test_reset_walkthrough();
		send_item(REQ_TICK, 16'h0000, 1'b0);
		send_item(REQ_TICK, 16'hFFFF, 1'b1);
		send_item(REQ_POLL, 16'h0000, 1'b0);  // same as stored level
		send_item(REQ_POLL, 16'hFFFF, 1'b1);  // start debounce
		send_item(REQ_POLL, 16'h0000, 1'b1);  // window still open
		send_item(REQ_TICK, 16'd19, 1'b0);
		send_item(REQ_POLL, 16'h0000, 1'b1);  // one unit left
		send_item(REQ_TICK, 16'd1, 1'b0);
		send_item(REQ_POLL, 16'h0000, 1'b1);  // accepted: pressed
		send_item(REQ_POLL, 16'h0000, 1'b1);  // hold time running
		send_item(REQ_TICK, 16'hFFFF, 1'b0);
		send_item(REQ_POLL, 16'h0000, 1'b1);  // long press
		send_item(REQ_POLL, 16'h0000, 1'b0);  // release starts debounce
		send_item(REQ_TICK, 16'd20, 1'b0);
		send_item(REQ_POLL, 16'h0000, 1'b1);  // bounced back to pressed
	endtask

	// zero debounce and zero hold time: long press disabled, short press
	// on release, idle countdown still running at entry
	task automatic test_short_press_no_long();
		program_regs(16'd0, 16'd0, 8'hFF);
		send_item(REQ_POLL, 16'hAAAA, 1'b0);  // countdown left from before
		send_item(REQ_TICK, 16'h5555, 1'b1);
		send_item(REQ_TICK, 16'hAAAA, 1'b0);
		send_item(REQ_POLL, 16'h5555, 1'b0);
		send_item(REQ_POLL, 16'h0000, 1'b0);  // released
		send_item(REQ_POLL, 16'h0000, 1'b1);
		send_item(REQ_POLL, 16'h0000, 1'b1);  // pressed
		send_item(REQ_POLL, 16'h0000, 1'b1);  // no long press while disabled
		send_item(REQ_TICK, 16'd5, 1'b0);
		send_item(REQ_POLL, 16'h0000, 1'b1);
		send_item(REQ_POLL, 16'h0000, 1'b0);  // short press
		send_item(REQ_POLL, 16'h0000, 1'b0);  // released
	endtask

	// random episodes under several settings, extremes among them
	task automatic test_random_settings();
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: program_regs(16'd5, 16'd40, 8'($urandom));
				1: program_regs(16'd0, 16'd0, 8'h00);
				2: program_regs(16'hFFFF, 16'hFFFF, 8'hFF);
				default: program_regs(16'($urandom_range(0, 100)),
					16'($urandom_range(1, 300)), 8'($urandom));
			endcase
			// alternate heavy and light idling
			tx_gap_pct   = (k % 2) ? 35 : 10;
			rx_stall_pct = (k % 2) ? 35 : 10;
			send_random(100);
		end
	endtask

	// receiver holds off for a long stretch while items keep coming,
	// so the unit fills up and drops in_ready
	task automatic test_output_backpressure();
		program_regs(16'd3, 16'd25, 8'h5A);
		tx_gap_pct      = 0;
		rx_stall_pct    = 0;
		hold_off_cycles = 150;
		send_random(60);
	endtask

	// closing stretch at full rate on both sides
	task automatic test_full_rate();
		program_regs(16'($urandom_range(0, 60)), 16'($urandom_range(1, 200)),
			8'($urandom));
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		send_random(70);
	endtask

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		in_data         <= '0;
		cfg_valid       <= 1'b0;
		cfg_index       <= '0;
		cfg_data        <= '0;
		tx_gap_pct      = 20;
		rx_stall_pct    = 20;
		hold_off_cycles = 0;
		held_level      = 1'b0;
		cycle_count     = 0;
		mismatch_count  = 0;
		items_sent      = 0;
		results_checked = 0;
		settings_used   = 1;
		event_seen      = '{default: 0};
		// predictor starts from the reset state
		pred_phase = PH_IDLE;
		pred_count = '0;
		pred_level = 1'b0;
		set_db     = DEBOUNCE_RST;
		set_lp     = LONG_PRESS_RST;
		set_id     = BUTTON_ID_RST;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_walkthrough();
		test_short_press_no_long();
		test_random_settings();
		test_output_backpressure();
		test_full_rate();
		drain_unit();

		$display("%0d transactions under %0d register settings, %0d results checked",
			items_sent, settings_used, results_checked);
		$display("events seen: %0d none, %0d updated, %0d short, %0d long",
			event_seen[EV_NONE], event_seen[EV_UPDATED], event_seen[EV_SHORT],
			event_seen[EV_LONG]);
		if (mismatch_count == 0 && predicted_events.size() == 0) begin
			$display("button_debounce_long_press_unit_tb: done, clean");
		end else begin
			$display("button_debounce_long_press_unit_tb: done, errors");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/bdlp_pkg.sv
rtl/core/button_debounce_long_press_unit.sv
tb/button_debounce_long_press_unit_tb.sv
